### rtl/utf8_cjk_presence_detector_unit_macros.svh
// ----------------------------------------------------------------------------
// UTF-8 CJK presence detector assertion macros
// Concurrent assertion wrappers used by the top-level detector file.
// ----------------------------------------------------------------------------
`ifndef UTF8_CJK_PRESENCE_DETECTOR_UNIT_MACROS_SVH
`define UTF8_CJK_PRESENCE_DETECTOR_UNIT_MACROS_SVH

// check a property on every edge outside reset
`define UCPD_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ucpd assertion failed");

// check a property on every edge, reset included
`define UCPD_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("ucpd assertion failed");

`endif

### rtl/ucpd_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 CJK presence detector package
// Widths, CJK ideograph range table, range check and shared structs.
// ----------------------------------------------------------------------------
package ucpd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CODE_W = 21;
  localparam int unsigned PEND_W = 2;
  localparam int unsigned CJK_RANGES = 9;

  localparam logic [CODE_W-1:0] CJK_LO [CJK_RANGES] = '{
    21'h04E00, 21'h03400, 21'h20000, 21'h2A700, 21'h2B740,
    21'h2B820, 21'h2CEB0, 21'h0F900, 21'h2F800
  };
  localparam logic [CODE_W-1:0] CJK_HI [CJK_RANGES] = '{
    21'h09FFF, 21'h04DBF, 21'h2A6DF, 21'h2B73F, 21'h2B81F,
    21'h2CEAF, 21'h2EBEF, 21'h0FAFF, 21'h2FA1F
  };

  typedef struct packed {
    logic contains_cjk;
    logic truncated_tail;
  } result_t;

  typedef struct packed {
    logic seq_open;
    logic cjk_seen;
  } dec_status_t;

  function automatic logic in_cjk_range(input logic [CODE_W-1:0] cp);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < CJK_RANGES; i++) begin
      if (cp >= CJK_LO[i] && cp <= CJK_HI[i]) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

### rtl/ucpd_decoder.sv
// ----------------------------------------------------------------------------
// UTF-8 CJK presence detector stream decoder
// Holds the open sequence and sticky hit flag, emits one result per string.
// ----------------------------------------------------------------------------
module ucpd_decoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [ucpd_pkg::BYTE_W-1:0]  data_byte_i,
  input  logic                         end_of_string_i,
  input  logic                         no_byte_i,
  output logic                         push_o,
  output ucpd_pkg::result_t            result_o,
  output ucpd_pkg::dec_status_t        status_o
);

  logic [ucpd_pkg::PEND_W-1:0] pend_q, pend_d, pend_nx;
  logic [ucpd_pkg::CODE_W-1:0] acc_q, acc_d, acc_nx;
  logic                        seen_q, seen_d, seen_nx;

  always_comb begin
    pend_nx = pend_q;
    acc_nx  = acc_q;
    seen_nx = seen_q;
    if (accept_i && !no_byte_i) begin
      if (pend_q != '0) begin
        acc_nx  = {acc_q[ucpd_pkg::CODE_W-7:0], data_byte_i[5:0]};
        pend_nx = pend_q - 2'd1;
        if (pend_q == 2'd1 && ucpd_pkg::in_cjk_range(acc_nx)) seen_nx = 1'b1;
      end else begin
        unique case (data_byte_i) inside
          [8'hC0:8'hDF]: begin
            acc_nx  = {16'd0, data_byte_i[4:0]};
            pend_nx = 2'd1;
          end
          [8'hE0:8'hEF]: begin
            acc_nx  = {17'd0, data_byte_i[3:0]};
            pend_nx = 2'd2;
          end
          [8'hF0:8'hF7]: begin
            acc_nx  = {18'd0, data_byte_i[2:0]};
            pend_nx = 2'd3;
          end
          default: ;
        endcase
      end
    end
  end

  assign push_o                  = accept_i && end_of_string_i;
  assign result_o.contains_cjk   = seen_nx;
  assign result_o.truncated_tail = (pend_nx != '0);

  always_comb begin
    if (push_o) begin
      pend_d = '0;
      acc_d  = '0;
      seen_d = 1'b0;
    end else begin
      pend_d = pend_nx;
      acc_d  = acc_nx;
      seen_d = seen_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      acc_q  <= '0;
      seen_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      acc_q  <= acc_d;
      seen_q <= seen_d;
    end
  end

  assign status_o.seq_open = (pend_q != '0);
  assign status_o.cjk_seen = seen_q;

endmodule

### rtl/ucpd_out_buf.sv
// ----------------------------------------------------------------------------
// UTF-8 CJK presence detector result buffer
// Output register with one skid entry so the input keeps flowing under stall.
// ----------------------------------------------------------------------------
module ucpd_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ucpd_pkg::result_t push_data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ucpd_pkg::result_t out_data_o
);

  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  ucpd_pkg::result_t out_data_q, out_data_d;
  ucpd_pkg::result_t skid_data_q, skid_data_d;
  logic              pop;

  assign pop = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (pop) begin
      if (skid_valid_q) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push_i;
        out_data_d  = push_data_i;
      end
    end else if (!out_valid_q) begin
      out_valid_d = push_i;
      out_data_d  = push_data_i;
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_data_d  = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### rtl/utf8_cjk_presence_detector_unit.sv
// ----------------------------------------------------------------------------
// UTF-8 CJK presence detector
// Decodes a UTF-8 byte stream and reports whether it holds a CJK ideograph.
// ----------------------------------------------------------------------------
// One byte is taken per cycle unless stalled; each byte passes through the
// sequence decoder and a nine-range compare in a single step, set by the
// decoder state registers. The request that ends a string produces its
// result in the output register on the next edge, or in the skid entry when
// a stalled result still holds the output register. A two-entry result buffer
// lets input run on while a result waits; in_stall_o rises only when both
// entries hold results that have not been taken.
`include "utf8_cjk_presence_detector_unit_macros.svh"

module utf8_cjk_presence_detector_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ucpd_pkg::BYTE_W-1:0]  data_byte_i,
  input  logic                         end_of_string_i,
  input  logic                         no_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         contains_cjk_o,
  output logic                         truncated_tail_o
);

  logic                  accept;
  logic                  push;
  logic                  full;
  ucpd_pkg::result_t     result;
  ucpd_pkg::result_t     out_data;
  ucpd_pkg::dec_status_t status;

  assign accept     = in_valid_i && !full;
  assign in_stall_o = full;

  ucpd_decoder u_decoder (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .data_byte_i     (data_byte_i),
    .end_of_string_i (end_of_string_i),
    .no_byte_i       (no_byte_i),
    .push_o          (push),
    .result_o        (result),
    .status_o        (status)
  );

  ucpd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (result),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign contains_cjk_o   = out_data.contains_cjk;
  assign truncated_tail_o = out_data.truncated_tail;

  `UCPD_ASSERT_ALWAYS(a_stall_needs_output, clk_i, in_stall_o |-> out_valid_o)
  `UCPD_ASSERT(a_end_clears_state, clk_i, rst_ni,
               push |=> !status.seq_open && !status.cjk_seen)
  `UCPD_ASSERT(a_end_fills_output, clk_i, rst_ni,
               (push && !out_valid_o) |=> out_valid_o)

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// UTF-8 CJK presence detector testbench
// Sends UTF-8 strings one byte per request to the detector and checks every
// end-of-string result against a cycle-free decoder model kept in the bench.
// The strings are directed corner cases first, then random strings made of
// ASCII, stray bytes, empty requests, overlong, truncated and corrupted
// sequences, and code points at the edges of the ideograph ranges. Both
// sides idle at random, with a long hold-off on the output and a pause on
// the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_LIMIT = 20000;
  localparam int unsigned TOTAL_ITEMS = 1100;

  localparam logic [ucpd_pkg::CODE_W-1:0] IDEO_FIRST [9] = '{
    21'h03400, 21'h04E00, 21'h0F900, 21'h20000, 21'h2A700,
    21'h2B740, 21'h2B820, 21'h2CEB0, 21'h2F800
  };
  localparam logic [ucpd_pkg::CODE_W-1:0] IDEO_LAST [9] = '{
    21'h04DBF, 21'h09FFF, 21'h0FAFF, 21'h2A6DF, 21'h2B73F,
    21'h2B81F, 21'h2CEAF, 21'h2EBEF, 21'h2FA1F
  };

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic [ucpd_pkg::BYTE_W-1:0] data_byte_i = '0;
  logic                        end_of_string_i = 1'b0;
  logic                        no_byte_i = 1'b0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic                        contains_cjk_o;
  logic                        truncated_tail_o;

  bit                idle_on = 1'b1;
  int unsigned       hold_req = 0;
  int unsigned       hold_left = 0;
  int unsigned       items_sent = 0;
  int unsigned       mismatches = 0;
  int unsigned       cycles = 0;

  logic [ucpd_pkg::PEND_W-1:0] dec_pending = '0;
  logic [ucpd_pkg::CODE_W-1:0] dec_code = '0;
  logic                        dec_seen = 1'b0;
  ucpd_pkg::result_t           expected_flags [$];
  ucpd_pkg::result_t           want;

  utf8_cjk_presence_detector_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .end_of_string_i  (end_of_string_i),
    .no_byte_i        (no_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .contains_cjk_o   (contains_cjk_o),
    .truncated_tail_o (truncated_tail_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic is_ideograph(input logic [ucpd_pkg::CODE_W-1:0] cp);
    logic hit;
    hit = 1'b0;
    for (int r = 0; r < 9; r++) begin
      if (cp >= IDEO_FIRST[r] && cp <= IDEO_LAST[r]) hit = 1'b1;
    end
    return hit;
  endfunction

  task automatic predict_request(input logic [ucpd_pkg::BYTE_W-1:0] b, input logic eos,
                                 input logic nb);
    ucpd_pkg::result_t res;
    if (!nb) begin
      if (dec_pending != 0) begin
        dec_code = {dec_code[ucpd_pkg::CODE_W-7:0], b[5:0]};
        dec_pending = dec_pending - 1'b1;
        if (dec_pending == 0 && is_ideograph(dec_code)) dec_seen = 1'b1;
      end else if (b[7:5] == 3'b110) begin
        dec_code = {16'd0, b[4:0]};
        dec_pending = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        dec_code = {17'd0, b[3:0]};
        dec_pending = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        dec_code = {18'd0, b[2:0]};
        dec_pending = 2'd3;
      end
    end
    if (eos) begin
      res.contains_cjk = dec_seen;
      res.truncated_tail = (dec_pending != 0);
      expected_flags.push_back(res);
      dec_pending = '0;
      dec_code = '0;
      dec_seen = 1'b0;
    end
  endtask

  task automatic send_request(input logic [ucpd_pkg::BYTE_W-1:0] b, input logic eos,
                              input logic nb);
    if (idle_on && $urandom_range(0, 99) < 19) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    end_of_string_i <= eos;
    no_byte_i <= nb;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_request(b, eos, nb);
    items_sent++;
  endtask

  // keep < len cuts the sequence short
  task automatic send_code_point(input logic [ucpd_pkg::CODE_W-1:0] cp, input int len,
                                 input logic last, input int keep);
    logic [7:0] seq [4];
    case (len)
      1: seq[0] = {1'b0, cp[6:0]};
      2: seq[0] = {3'b110, cp[10:6]};
      3: seq[0] = {4'b1110, cp[15:12]};
      default: seq[0] = {5'b11110, cp[20:18]};
    endcase
    for (int k = 1; k < len; k++) begin
      seq[k] = {2'b10, cp[6*(len-1-k) +: 6]};
      if ($urandom_range(0, 99) < 8) seq[k][7:6] = 2'($urandom_range(0, 3));
    end
    for (int k = 0; k < keep; k++) send_request(seq[k], last && (k == keep - 1), 1'b0);
  endtask

  function automatic logic [ucpd_pkg::CODE_W-1:0] pick_code_point();
    int sel;
    int r;
    sel = $urandom_range(0, 9);
    r = $urandom_range(0, 8);
    if (sel < 2) return ucpd_pkg::CODE_W'($urandom_range(16'h0080, 16'h07FF));
    if (sel < 3) return ucpd_pkg::CODE_W'($urandom_range(0, 21'h1FFFFF));
    case ($urandom_range(0, 4))
      0: return IDEO_FIRST[r] - 1'b1;
      1: return IDEO_FIRST[r];
      2: return IDEO_LAST[r];
      3: return IDEO_LAST[r] + 1'b1;
      default: return ucpd_pkg::CODE_W'($urandom_range(IDEO_FIRST[r], IDEO_LAST[r]));
    endcase
  endfunction

  task automatic send_random_string(input int max_cp);
    int n_cp;
    int kind;
    int len;
    int keep;
    bit own_end;
    logic last;
    logic [ucpd_pkg::CODE_W-1:0] cp;
    n_cp = $urandom_range(1, max_cp);
    own_end = ($urandom_range(0, 1) == 1);
    for (int i = 0; i < n_cp; i++) begin
      last = !own_end && (i == n_cp - 1);
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        send_request($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                          : 8'($urandom_range(8'hF8, 8'hFF)), last, 1'b0);
      end else if (kind < 14) begin
        send_request(8'($urandom_range(0, 255)), last, 1'b1);
      end else if (kind < 30) begin
        send_code_point(ucpd_pkg::CODE_W'($urandom_range(0, 127)), 1, last, 1);
      end else begin
        cp = pick_code_point();
        len = (cp < 'h80) ? 1 : (cp < 'h800) ? 2 : (cp < 'h10000) ? 3 : 4;
        if (len < 4 && $urandom_range(0, 99) < 10) len++;
        keep = len;
        if (len > 1 && $urandom_range(0, 99) < ((i == n_cp - 1) ? 12 : 4))
          keep = $urandom_range(1, len - 1);
        send_code_point(cp, len, last, keep);
      end
    end
    if (own_end) send_request(8'($urandom_range(0, 255)), 1'b1, 1'b1);
  endtask

  task automatic wait_all_results();
    int unsigned waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (expected_flags.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
  endtask

  task automatic test_directed();
    send_request(8'h00, 1'b1, 1'b1);
    send_request(8'h00, 1'b0, 1'b0);
    send_request(8'h7F, 1'b0, 1'b0);
    send_request(8'h80, 1'b0, 1'b0);
    send_request(8'hBF, 1'b0, 1'b0);
    send_request(8'hF8, 1'b0, 1'b0);
    send_request(8'hFF, 1'b1, 1'b0);
    send_request(8'hE4, 1'b0, 1'b0);
    send_request(8'hB8, 1'b0, 1'b0);
    send_request(8'h80, 1'b0, 1'b0);
    send_request(8'hEF, 1'b0, 1'b0);
    send_request(8'hA4, 1'b0, 1'b0);
    send_request(8'h55, 1'b1, 1'b1);
    send_request(8'hF0, 1'b0, 1'b0);
    send_request(8'hA0, 1'b0, 1'b0);
    send_request(8'h80, 1'b0, 1'b0);
    send_request(8'h80, 1'b1, 1'b0);
    send_request(8'hC3, 1'b0, 1'b0);
    send_request(8'hF5, 1'b1, 1'b0);
    send_request(8'hE3, 1'b0, 1'b0);
    send_request(8'hAA, 1'b0, 1'b1);
    send_request(8'h90, 1'b0, 1'b0);
    send_request(8'h80, 1'b0, 1'b0);
    send_request(8'hFF, 1'b1, 1'b1);
  endtask

  task automatic test_random_strings(input int unsigned upto);
    while (items_sent < upto) send_random_string(6);
  endtask

  task automatic test_steady_stream(input int unsigned count);
    int unsigned stop;
    stop = items_sent + count;
    idle_on <= 1'b0;
    while (items_sent < stop) send_random_string(6);
    idle_on <= 1'b1;
  endtask

  task automatic test_output_hold_off();
    int unsigned stop;
    stop = items_sent + 60;
    hold_req <= 400;
    while (items_sent < stop) send_random_string(2);
  endtask

  task automatic test_sender_pause();
    repeat (5) send_random_string(4);
    wait_all_results();
    repeat (5) send_random_string(4);
  endtask

  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left <= hold_req - 1;
      hold_req <= 0;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (idle_on) begin
      out_stall_i <= ($urandom_range(0, 99) < 19);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_flags.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: contains_cjk=%0b truncated_tail=%0b",
                   contains_cjk_o, truncated_tail_o);
      end else begin
        want = expected_flags.pop_front();
        if (contains_cjk_o !== want.contains_cjk ||
            truncated_tail_o !== want.truncated_tail) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: contains_cjk exp %0b got %0b, truncated_tail exp %0b got %0b",
                     want.contains_cjk, contains_cjk_o, want.truncated_tail, truncated_tail_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_strings(500);
    test_steady_stream(150);
    test_output_hold_off();
    test_sender_pause();
    test_random_strings(TOTAL_ITEMS);
    in_valid_i <= 1'b0;
    wait_all_results();
    if (expected_flags.size() != 0) mismatches++;
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
